// ----- rtl/core/tcmd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcmd_pkg
// Types and codes shared by the tagged chunk message deframer and its checker.
// ----------------------------------------------------------------------------
package tcmd_pkg;

  localparam int unsigned HdrBytes  = 7;
  localparam int unsigned ChunkMin  = 7;
  localparam int unsigned LenBytes  = 4;

  localparam logic [2:0] KIND_HDR_OK   = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_MSG_END  = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_VERSION   = 2'd1;
  localparam logic [1:0] ERR_OVERRUN   = 2'd2;

  localparam logic [2:0] REG_EXP_VER   = 3'd0;

  typedef enum logic [5:0] {
    PH_DISCARD = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_CTAG    = 6'b000100,
    PH_CLEN    = 6'b001000,
    PH_CDATA   = 6'b010000,
    PH_CTERM   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  item_tag;
    logic [7:0]  priority_res;
    logic [31:0] length;
    logic [7:0]  data;
    logic        last_in_chunk;
    logic [1:0]  error_code;
  } res_t;

endpackage

// ----- rtl/core/tagged_chunk_message_deframer.sv -----
// ----------------------------------------------------------------------------
// tagged_chunk_message_deframer
// Parses a byte stream of tagged, chunked messages into header, data-byte,
// empty-chunk, message-end and error results.
// ----------------------------------------------------------------------------
// One byte is taken per clock and every request is handled in the cycle it
// is accepted; the result (if any) lands in an output register backed by a
// one-entry skid stage, so the input keeps flowing while a result waits.
// Sustained rate is one byte per cycle while results drain; in_ready drops
// only while the skid stage is occupied. expected_version is at byte
// address 0 of the APB port and should be written while the stream is idle.
module tagged_chunk_message_deframer
  import tcmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_item_tag,
  output logic [7:0]  out_priority_res,
  output logic [31:0] out_length,
  output logic [7:0]  out_data,
  output logic        out_last_in_chunk,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  exp_ver_r;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  mtag_r, mtag_nxt;
  logic [7:0]  mprio_r, mprio_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [31:0] prem_r, prem_nxt;
  logic [7:0]  ctag_r, ctag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] crem_r, crem_nxt;

  logic        out_vld_r, out_vld_nxt;
  res_t        out_r, out_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  res_t        skid_r, skid_nxt;

  logic        accept;
  logic        res_vld;
  res_t        res;
  logic [31:0] plen_full;
  logic [31:0] clen_full;
  logic [31:0] prem_dec;
  logic [31:0] crem_dec;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXP_VER[0]) ? {24'd0, exp_ver_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= 8'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_EXP_VER[0]) begin
      exp_ver_r <= pwdata[7:0];
    end
  end

  assign in_ready  = !skid_vld_r;
  assign accept    = in_valid && in_ready;
  assign plen_full = {plen_r[23:0], in_byte_in};
  assign clen_full = {clen_r[23:0], in_byte_in};
  assign prem_dec  = prem_r - 32'd1;
  assign crem_dec  = crem_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ver_nxt   = ver_r;
    mtag_nxt  = mtag_r;
    mprio_nxt = mprio_r;
    plen_nxt  = plen_r;
    prem_nxt  = prem_r;
    ctag_nxt  = ctag_r;
    clen_nxt  = clen_r;
    crem_nxt  = crem_r;
    res_vld   = 1'b0;
    res       = '0;
    if (in_first) begin
      phase_nxt = PH_HEADER;
      ver_nxt   = in_byte_in;
      cnt_nxt   = 3'd1;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (cnt_r == 3'd1) begin
            mtag_nxt = in_byte_in;
          end else if (cnt_r == 3'd2) begin
            mprio_nxt = in_byte_in;
          end else begin
            plen_nxt = plen_full;
          end
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'(HdrBytes - 1)) begin
            cnt_nxt = 3'd0;
            res_vld = 1'b1;
            if (ver_r != exp_ver_r) begin
              phase_nxt      = PH_DISCARD;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_VERSION;
            end else begin
              prem_nxt         = plen_full;
              phase_nxt        = (plen_full == 32'd0) ? PH_DISCARD : PH_CTAG;
              res.kind         = KIND_HDR_OK;
              res.item_tag     = mtag_r;
              res.priority_res = mprio_r;
              res.length       = plen_full;
            end
          end
        end
        PH_CTAG: begin
          if (prem_r < 32'(ChunkMin)) begin
            phase_nxt      = PH_DISCARD;
            res_vld        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OVERRUN;
          end else begin
            ctag_nxt  = in_byte_in;
            prem_nxt  = prem_dec;
            cnt_nxt   = 3'd0;
            clen_nxt  = 32'd0;
            phase_nxt = PH_CLEN;
          end
        end
        PH_CLEN: begin
          clen_nxt = clen_full;
          prem_nxt = prem_dec;
          cnt_nxt  = cnt_r + 3'd1;
          if (cnt_r == 3'(LenBytes - 1)) begin
            cnt_nxt  = 3'd0;
            crem_nxt = clen_full;
            // length plus terminator must fit in what remains
            if (clen_full >= prem_dec) begin
              phase_nxt      = PH_DISCARD;
              res_vld        = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_OVERRUN;
            end else if (clen_full == 32'd0) begin
              phase_nxt        = PH_CTERM;
              res_vld          = 1'b1;
              res.kind         = KIND_EMPTY;
              res.item_tag     = ctag_r;
              res.priority_res = mprio_r;
            end else begin
              phase_nxt = PH_CDATA;
            end
          end
        end
        PH_CDATA: begin
          prem_nxt = prem_dec;
          crem_nxt = crem_dec;
          if (crem_dec == 32'd0) begin
            phase_nxt = PH_CTERM;
          end
          res_vld           = 1'b1;
          res.kind          = KIND_DATA;
          res.item_tag      = ctag_r;
          res.priority_res  = mprio_r;
          res.length        = clen_r;
          res.data          = in_byte_in;
          res.last_in_chunk = (crem_dec == 32'd0);
        end
        PH_CTERM: begin
          prem_nxt = prem_dec;
          if (prem_dec == 32'd0) begin
            phase_nxt        = PH_DISCARD;
            res_vld          = 1'b1;
            res.kind         = KIND_MSG_END;
            res.item_tag     = mtag_r;
            res.priority_res = mprio_r;
            res.length       = plen_r;
          end else begin
            phase_nxt = PH_CTAG;
          end
        end
        default: begin
          phase_nxt = PH_DISCARD;
        end
      endcase
    end
  end

  // output register with skid stage
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (out_vld_r && !out_ready) begin
      if (accept && res_vld) begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = res;
      end
    end else if (skid_vld_r) begin
      out_vld_nxt  = 1'b1;
      out_nxt      = skid_r;
      skid_vld_nxt = 1'b0;
    end else if (accept && res_vld) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
    end else begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DISCARD;
      cnt_r      <= 3'd0;
      ver_r      <= 8'd0;
      mtag_r     <= 8'd0;
      mprio_r    <= 8'd0;
      plen_r     <= 32'd0;
      prem_r     <= 32'd0;
      ctag_r     <= 8'd0;
      clen_r     <= 32'd0;
      crem_r     <= 32'd0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        ver_r   <= ver_nxt;
        mtag_r  <= mtag_nxt;
        mprio_r <= mprio_nxt;
        plen_r  <= plen_nxt;
        prem_r  <= prem_nxt;
        ctag_r  <= ctag_nxt;
        clen_r  <= clen_nxt;
        crem_r  <= crem_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_kind          = out_r.kind;
  assign out_item_tag      = out_r.item_tag;
  assign out_priority_res  = out_r.priority_res;
  assign out_length        = out_r.length;
  assign out_data          = out_r.data;
  assign out_last_in_chunk = out_r.last_in_chunk;
  assign out_error_code    = out_r.error_code;

endmodule

// ----- rtl/core/tcmd_checker.sv -----
// ----------------------------------------------------------------------------
// tcmd_checker
// Port-level checks for the tagged chunk message deframer.
// ----------------------------------------------------------------------------
module tcmd_checker
  import tcmd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_item_tag,
  input logic [31:0] out_length,
  input logic [7:0]  out_data,
  input logic        out_last_in_chunk,
  input logic [1:0]  out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data))
    else $error("result changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |->
      out_item_tag == 8'd0 && out_length == 32'd0 && out_data == 8'd0)
    else $error("error result carries payload");

  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_chunk |-> out_kind == KIND_DATA)
    else $error("last mark on non-data result");

  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid) && out_valid)
    else $error("input stalled without a pending result");

endmodule

bind tagged_chunk_message_deframer tcmd_checker u_tcmd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_item_tag      (out_item_tag),
  .out_length        (out_length),
  .out_data          (out_data),
  .out_last_in_chunk (out_last_in_chunk),
  .out_error_code    (out_error_code)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tagged chunk message deframer against a cycle-free predictor of
// its parse state. A negedge driver feeds bytes from a request queue, a
// posedge monitor runs the predictor on every accepted request and matches
// every returned result field by field. Phases vary the expected version
// and the idling of both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tcmd_pkg::*;

  typedef struct packed {
    logic       first;
    logic [7:0] value;
  } byte_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'd0;
  logic        in_first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_item_tag;
  logic [7:0]  out_priority_res;
  logic [31:0] out_length;
  logic [7:0]  out_data;
  logic        out_last_in_chunk;
  logic [1:0]  out_error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  tagged_chunk_message_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .in_first         (in_first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_item_tag     (out_item_tag),
    .out_priority_res (out_priority_res),
    .out_length       (out_length),
    .out_data         (out_data),
    .out_last_in_chunk(out_last_in_chunk),
    .out_error_code   (out_error_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // predictor state
  logic [7:0]  exp_ver = 8'd0;
  phase_t      dfr_phase = PH_DISCARD;
  logic [2:0]  hdr_count = 3'd0;
  logic [2:0]  len_count = 3'd0;
  logic [7:0]  ver_seen = 8'd0;
  logic [7:0]  msg_tag = 8'd0;
  logic [7:0]  msg_prio = 8'd0;
  logic [31:0] pay_len = 32'd0;
  logic [31:0] pay_idx = 32'd0;
  logic [7:0]  chk_tag = 8'd0;
  logic [31:0] chk_len = 32'd0;
  logic [31:0] chk_rem = 32'd0;

  byte_req_t   byte_stream[$];
  byte_req_t   staged[$];
  byte_req_t   drive_req;
  res_t        expected_results[$];
  res_t        predicted;
  res_t        want;
  logic        in_fire = 1'b0;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned counted_bytes = 0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL tagged_chunk_message_deframer");
    $finish;
  end

  function automatic void flag_error(input logic [1:0] code, inout res_t r);
    dfr_phase    = PH_DISCARD;
    r.kind       = KIND_ERROR;
    r.error_code = code;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic f, output res_t r);
    bit got;
    r   = '0;
    got = 1'b0;
    if (f) begin
      dfr_phase = PH_HEADER;
      ver_seen  = b;
      hdr_count = 3'd1;
    end else begin
      case (dfr_phase)
        PH_HEADER: begin
          case (hdr_count)
            3'd1: msg_tag = b;
            3'd2: msg_prio = b;
            3'd3: pay_len = {24'd0, b};
            default: pay_len = {pay_len[23:0], b};
          endcase
          hdr_count++;
          if (hdr_count == 3'(HdrBytes)) begin
            hdr_count = 3'd0;
            got = 1'b1;
            if (ver_seen != exp_ver) begin
              flag_error(ERR_VERSION, r);
            end else begin
              pay_idx        = 32'd0;
              dfr_phase      = (pay_len == 32'd0) ? PH_DISCARD : PH_CTAG;
              r.kind         = KIND_HDR_OK;
              r.item_tag     = msg_tag;
              r.priority_res = msg_prio;
              r.length       = pay_len;
            end
          end
        end
        PH_CTAG: begin
          if (pay_len - pay_idx < ChunkMin) begin
            got = 1'b1;
            flag_error(ERR_OVERRUN, r);
          end else begin
            chk_tag   = b;
            pay_idx++;
            len_count = 3'd0;
            chk_len   = 32'd0;
            dfr_phase = PH_CLEN;
          end
        end
        PH_CLEN: begin
          chk_len = {chk_len[23:0], b};
          pay_idx++;
          len_count++;
          if (len_count == 3'(LenBytes)) begin
            len_count = 3'd0;
            // chunk data plus its terminator must fit in the payload left
            if ({1'b0, chk_len} + 33'd1 > {1'b0, pay_len - pay_idx}) begin
              got = 1'b1;
              flag_error(ERR_OVERRUN, r);
            end else begin
              chk_rem = chk_len;
              if (chk_len == 32'd0) begin
                dfr_phase      = PH_CTERM;
                got            = 1'b1;
                r.kind         = KIND_EMPTY;
                r.item_tag     = chk_tag;
                r.priority_res = msg_prio;
              end else begin
                dfr_phase = PH_CDATA;
              end
            end
          end
        end
        PH_CDATA: begin
          pay_idx++;
          chk_rem--;
          if (chk_rem == 32'd0) dfr_phase = PH_CTERM;
          got             = 1'b1;
          r.kind          = KIND_DATA;
          r.item_tag      = chk_tag;
          r.priority_res  = msg_prio;
          r.length        = chk_len;
          r.data          = b;
          r.last_in_chunk = (chk_rem == 32'd0);
        end
        PH_CTERM: begin
          pay_idx++;
          if (pay_idx == pay_len) begin
            dfr_phase      = PH_DISCARD;
            got            = 1'b1;
            r.kind         = KIND_MSG_END;
            r.item_tag     = msg_tag;
            r.priority_res = msg_prio;
            r.length       = pay_len;
          end else begin
            dfr_phase = PH_CTAG;
          end
        end
        default: dfr_phase = PH_DISCARD;
      endcase
    end
    return got;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle) begin
        drive_req = byte_stream.pop_front();
        in_valid   <= 1'b1;
        in_byte_in <= drive_req.value;
        in_first   <= drive_req.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (deframe_byte(in_byte_in, in_first, predicted)) expected_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d", out_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("item_tag", 32'(want.item_tag), 32'(out_item_tag));
          check_field("priority_res", 32'(want.priority_res), 32'(out_priority_res));
          check_field("length", want.length, out_length);
          check_field("data", 32'(want.data), 32'(out_data));
          check_field("last_in_chunk", 32'(want.last_in_chunk), 32'(out_last_in_chunk));
          check_field("error_code", 32'(want.error_code), 32'(out_error_code));
        end
      end
    end
  end

  task automatic add_byte(input logic f, input logic [7:0] b);
    staged.push_back('{first: f, value: b});
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(1'b0, w[8*i +: 8]);
  endtask

  task automatic flush_staged(input bit counted);
    if (counted) counted_bytes += staged.size();
    while (staged.size() != 0) byte_stream.push_back(staged.pop_front());
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] wval);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wval;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == 3'(4 * REG_EXP_VER)) exp_ver = wval[7:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    int unsigned spin;
    spin = 0;
    while ((byte_stream.size() != 0 || in_valid || expected_results.size() != 0)
           && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (6) @(posedge clk);
  endtask

  // one message, either well formed or with a bad version, no payload, slack
  // bytes, a bad chunk length, a huge payload length or a cut; or stray bytes alone
  task automatic gen_message();
    int unsigned sel;
    int unsigned nchunks;
    int unsigned bad_k;
    int unsigned keep;
    int unsigned lens[4];
    logic [31:0] plen_v;
    logic [31:0] len_field;
    logic [7:0]  ver;
    sel = $urandom_range(99);
    staged.delete();
    if (sel < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(1'b0, 8'($urandom));
      flush_staged(1'b0);
    end else begin
      ver     = (sel < 16) ? exp_ver ^ 8'($urandom_range(1, 255)) : exp_ver;
      nchunks = $urandom_range(1, 4);
      plen_v  = 32'd0;
      for (int i = 0; i < nchunks; i++) begin
        lens[i] = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        plen_v += 6 + lens[i];
      end
      if (sel >= 16 && sel < 22) plen_v = 32'd0;
      else if (sel < 30) plen_v += $urandom_range(1, 8);
      else if (sel >= 38 && sel < 46) plen_v = $urandom;
      bad_k = (sel >= 30 && sel < 38) ? $urandom_range(0, nchunks - 1) : 4;
      add_byte(1'b1, ver);
      add_byte(1'b0, 8'($urandom));
      add_byte(1'b0, 8'($urandom));
      add_word(plen_v);
      if (!(sel >= 16 && sel < 22)) begin
        for (int i = 0; i < nchunks; i++) begin
          add_byte(1'b0, 8'($urandom));
          len_field = lens[i];
          if (i == bad_k)
            len_field = $urandom_range(1) ? lens[i] + $urandom_range(1, 3)
                                          : ($urandom | 32'h8000_0000);
          add_word(len_field);
          repeat (lens[i]) add_byte(1'b0, 8'($urandom));
          add_byte(1'b0, 8'($urandom));
        end
      end
      if (sel >= 46 && sel < 52) begin
        keep = $urandom_range(1, staged.size() - 1);
        while (staged.size() > keep) void'(staged.pop_back());
      end
      flush_staged(1'b1);
    end
  endtask

  initial begin
    int unsigned phase_target;
    logic [7:0]  next_ver;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      if (ph_i != 0) begin
        wait_drained();
        next_ver = (ph_i == 1) ? 8'hFF : (ph_i == 2) ? 8'h00 : 8'($urandom_range(255));
        apb_write(3'(4 * REG_EXP_VER), {24'd0, next_ver});
      end
      case (ph_i % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      if (ph_i == 0) begin
        staged.delete();
        add_byte(1'b0, 8'hFF);                 // stray byte while discarding
        add_byte(1'b1, 8'h55);                 // header cut short by a restart
        add_byte(1'b0, 8'h00);
        add_byte(1'b0, 8'hFF);
        add_byte(1'b1, 8'h00);                 // empty chunk, then a one-byte chunk
        add_byte(1'b0, 8'hFF);
        add_byte(1'b0, 8'h80);
        add_word(32'd13);
        add_byte(1'b0, 8'h00);
        add_word(32'd0);
        add_byte(1'b0, 8'hFF);
        add_byte(1'b0, 8'hFF);
        add_word(32'd1);
        add_byte(1'b0, 8'hFF);
        add_byte(1'b0, 8'h00);
        add_byte(1'b1, 8'h00);                 // zero payload length
        add_byte(1'b0, 8'h01);
        add_byte(1'b0, 8'h7F);
        add_word(32'd0);
        add_byte(1'b1, 8'h80);                 // version mismatch
        add_byte(1'b0, 8'h02);
        add_byte(1'b0, 8'h03);
        add_word(32'hFFFF_FFFF);
        add_byte(1'b1, 8'h00);                 // chunk longer than what remains
        add_byte(1'b0, 8'hAA);
        add_byte(1'b0, 8'h55);
        add_word(32'd8);
        add_byte(1'b0, 8'h11);
        add_word(32'd3);
        add_byte(1'b1, 8'h00);                 // chunk start with too few bytes left
        add_byte(1'b0, 8'h5A);
        add_byte(1'b0, 8'hA5);
        add_word(32'd6);
        add_byte(1'b0, 8'h22);
        flush_staged(1'b1);
      end
      phase_target = counted_bytes + 95;
      while (counted_bytes < phase_target) gen_message();
    end

    wait_drained();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS tagged_chunk_message_deframer");
    end else begin
      $display("FAIL tagged_chunk_message_deframer");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tcmd_pkg.sv
rtl/core/tagged_chunk_message_deframer.sv
rtl/core/tcmd_checker.sv
tb/testbench.sv
